/* hw/rtl/fwc_pkg.sv */
// ----------------------------------------------------------------------------
// fwc_pkg
// Shared types and constants of the framed word checksum core.
// ----------------------------------------------------------------------------
package fwc_pkg;

   localparam logic [15:0] MAX_LEN_BYTES = 16'd4092;
   localparam logic [15:0] LEN_INVALID   = 16'hFFFF;

   typedef enum logic {
      CMD_HEADER = 1'b0,
      CMD_DATA   = 1'b1
   } command_type;

   typedef enum logic {
      MODE_CHECK = 1'b0,
      MODE_MAKE  = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_TOO_LONG   = 3'd2,
      ST_INCOMPLETE = 3'd3,
      ST_MISMATCH   = 3'd4
   } status_type;

   typedef struct packed {
      logic        command;
      logic [31:0] word;
      logic [15:0] length_bytes;
   } beat_type;

   typedef struct packed {
      logic     valid;
      beat_type beat;
   } stage_type;

endpackage

/* hw/rtl/fwc_in_stage.sv */
// ----------------------------------------------------------------------------
// fwc_in_stage
// Input register: holds one accepted request beat until the engine takes it.
// ----------------------------------------------------------------------------
module fwc_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fwc_pkg::beat_type  req_beat,
   input  logic               take,
   output fwc_pkg::stage_type stage
);

   logic              valid_ff;
   logic              valid_in;
   fwc_pkg::beat_type beat_ff;
   logic              load;

   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;
   assign valid_in  = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= req_beat;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.beat  = beat_ff;

endmodule

/* hw/rtl/fwc_engine.sv */
// ----------------------------------------------------------------------------
// fwc_engine
// Message state, running sum, length checks and the result register.
// ----------------------------------------------------------------------------
module fwc_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   input  fwc_pkg::stage_type stage,
   output logic               take,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_msg_length,
   output logic [31:0]        rsp_header_out
);

   logic        mode_ff;
   logic [31:0] acc_ff,       acc_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] msg_len_ff,   msg_len_in;
   logic        in_msg_ff,    in_msg_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff;
   logic [15:0] length_ff;
   logic [31:0] header_ff;

   logic        emit;
   logic [2:0]  res_status;
   logic [15:0] res_length;
   logic [31:0] res_header;

   logic [15:0] dlen;
   logic [31:0] mask;
   logic [31:0] sum;
   logic [15:0] fold;

   assign take = stage.valid && (!rsp_valid_ff || rsp_ready);
   assign dlen = stage.beat.word[15:0];

   always_comb begin
      case (bytes_left_ff[1:0])
         2'd1:    mask = 32'h0000_00FF;
         2'd2:    mask = 32'h0000_FFFF;
         2'd3:    mask = 32'h00FF_FFFF;
         default: mask = 32'hFFFF_FFFF;
      endcase
   end

   // last word keeps only its valid low bytes
   assign sum  = (bytes_left_ff[15:2] != 14'd0) ? acc_ff + stage.beat.word
                                                : acc_ff + (stage.beat.word & mask);
   assign fold = sum[15:0] + sum[31:16];

   always_comb begin
      acc_in        = acc_ff;
      bytes_left_in = bytes_left_ff;
      msg_len_in    = msg_len_ff;
      in_msg_in     = in_msg_ff;
      emit          = 1'b0;
      res_status    = fwc_pkg::ST_OK;
      res_length    = msg_len_ff;
      res_header    = 32'd0;
      if (take) begin
         if (stage.beat.command == fwc_pkg::CMD_HEADER) begin
            in_msg_in     = 1'b0;
            bytes_left_in = 16'd0;
            if (mode_ff == fwc_pkg::MODE_CHECK) begin
               msg_len_in = dlen;
               res_length = dlen;
               if (dlen == 16'd0 || dlen == fwc_pkg::LEN_INVALID) begin
                  emit       = 1'b1;
                  res_status = fwc_pkg::ST_EMPTY;
               end else if (dlen > fwc_pkg::MAX_LEN_BYTES) begin
                  emit       = 1'b1;
                  res_status = fwc_pkg::ST_TOO_LONG;
               end else if (dlen > stage.beat.length_bytes) begin
                  emit       = 1'b1;
                  res_status = fwc_pkg::ST_INCOMPLETE;
               end else begin
                  acc_in        = stage.beat.word;
                  bytes_left_in = dlen;
                  in_msg_in     = 1'b1;
               end
            end else begin
               msg_len_in = stage.beat.length_bytes;
               res_length = stage.beat.length_bytes;
               acc_in     = {16'd0, stage.beat.length_bytes};
               if (stage.beat.length_bytes == 16'd0) begin
                  // empty make request: header of all zeros
                  emit = 1'b1;
               end else begin
                  bytes_left_in = stage.beat.length_bytes;
                  in_msg_in     = 1'b1;
               end
            end
         end else if (in_msg_ff) begin
            acc_in        = sum;
            bytes_left_in = (bytes_left_ff[15:2] != 14'd0) ? bytes_left_ff - 16'd4 : 16'd0;
            if (bytes_left_in == 16'd0) begin
               in_msg_in = 1'b0;
               emit      = 1'b1;
               if (mode_ff == fwc_pkg::MODE_CHECK) begin
                  res_status = (fold != 16'd0) ? fwc_pkg::ST_MISMATCH : fwc_pkg::ST_OK;
               end else begin
                  res_header = {16'd0 - fold, msg_len_ff};
               end
            end
         end
      end
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= fwc_pkg::MODE_CHECK;
         acc_ff        <= 32'd0;
         bytes_left_ff <= 16'd0;
         msg_len_ff    <= 16'd0;
         in_msg_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         acc_ff        <= acc_in;
         bytes_left_ff <= bytes_left_in;
         msg_len_ff    <= msg_len_in;
         in_msg_ff     <= in_msg_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         status_ff <= res_status;
         length_ff <= res_length;
         header_ff <= res_header;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_msg_length = length_ff;
   assign rsp_header_out = header_ff;

   // an open message always has bytes still to come
   a_open_has_bytes : assert property (@(posedge clock) disable iff (reset)
      in_msg_ff |-> (bytes_left_ff != 16'd0 && bytes_left_ff <= msg_len_ff))
      else $error("open message with no bytes left");

   // every result closes the message
   a_result_closes : assert property (@(posedge clock) disable iff (reset)
      emit |=> !in_msg_ff)
      else $error("message still open after a result");

   // error results never carry a generated header
   a_err_no_header : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != fwc_pkg::ST_OK) |-> header_ff == 32'd0)
      else $error("error result with a header");

   // a result can only be loaded from a taken beat
   a_emit_needs_take : assert property (@(posedge clock) disable iff (reset)
      emit |-> (take && stage.valid))
      else $error("result without a beat");

endmodule

/* hw/rtl/framed_word_checksum_core.sv */
// ----------------------------------------------------------------------------
// framed_word_checksum_core
// Checks or builds the length/checksum header of a framed word message.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : request beats; a header beat (command 0) starts a message and
//            is followed by one data beat (command 1) per 32-bit word.
//   rsp_*  : one result beat per finished or rejected message: status,
//            message length and, in make mode, the generated header.
//   csr_*  : mode register, 0 check, 1 make; write only while idle.
// Result path: an accepted beat waits in the input register; the result
//   it causes is loaded into the result register when the engine takes
//   that beat (input register, then result register).
// Throughput: one request beat per cycle unless a result stalls; the running
//   sum is one 32-bit add and 16-bit fold per beat between the registers.
// Reset clears the mode to check, drops any open message and empties both
//   registers. When the receiver stalls, the result is held, the input
//   register holds at most one more beat and req_ready stays low until the
//   result is taken.
// ----------------------------------------------------------------------------
module framed_word_checksum_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_word,
   input  logic [15:0] req_length_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_msg_length,
   output logic [31:0] rsp_header_out
);

   fwc_pkg::beat_type  req_beat;
   fwc_pkg::stage_type stage;
   logic               take;

   assign req_beat.command      = req_command;
   assign req_beat.word         = req_word;
   assign req_beat.length_bytes = req_length_bytes;

   fwc_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .take      (take),
      .stage     (stage)
   );

   fwc_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .stage          (stage),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_msg_length (rsp_msg_length),
      .rsp_header_out (rsp_header_out)
   );

endmodule
